@@ rtl/core/pre_pkg.sv @@
package pre_pkg;

    // build-time defaults
    localparam int MAX_FRAMES_DEF     = 64;
    localparam int PAGE_SHIFT_DEF     = 13;
    localparam int REF_COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int PAGE_W    = 19;
    localparam int STAMP_W   = 32;
    localparam int ACC_W     = 40;
    localparam int CNT_W     = 32;
    localparam int NFR_W     = 7;
    localparam int POL_W     = 2;
    localparam int OP_W      = 2;
    localparam int VA_W      = 32;
    localparam int OUTC_W    = 2;
    localparam int FIDX_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 136;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'd1;

    // policies
    localparam logic [POL_W-1:0] POL_CLOCK = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
    localparam logic [POL_W-1:0] POL_NFU   = 2'd2;

    // access kinds
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // outcomes
    localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FREE  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_CLEAN = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_DIRTY = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOOK   = 9'b000000010,
        S_CHOOSE = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_MOD    = 9'b000010000,
        S_CRD    = 9'b000100000,
        S_CEV    = 9'b001000000,
        S_WRITE  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic load;
        logic look;
        logic choose;
        logic scan;
        logic modr;
        logic crd;
        logic cev;
        logic wr;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic hit_now;
        logic look_miss;
        logic room;
        logic scan_done;
        logic mod_done;
        logic ref_nz;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/pre_ram.sv @@
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/pre_ctrl.sv @@
module pre_ctrl import pre_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [POL_W-1:0] i_policy,
    input  t_status          i_st,
    output t_cmd             o_cmd
);
    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LOOK;
            S_LOOK: begin
                if (i_st.hit_now) n_state = S_WRITE;
                else if (i_st.look_miss) n_state = S_CHOOSE;
            end
            S_CHOOSE: begin
                if (i_st.room) n_state = S_WRITE;
                else if (i_policy == POL_LRU || i_policy == POL_NFU) n_state = S_SCAN;
                else n_state = S_MOD;
            end
            S_SCAN:   if (i_st.scan_done) n_state = S_WRITE;
            S_MOD:    if (i_st.mod_done) n_state = S_CRD;
            S_CRD:    n_state = S_CEV;
            S_CEV:    n_state = i_st.ref_nz ? S_CRD : S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (i_st.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.look   = (r_state == S_LOOK);
        o_cmd.choose = (r_state == S_CHOOSE);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.modr   = (r_state == S_MOD);
        o_cmd.crd    = (r_state == S_CRD);
        o_cmd.cev    = (r_state == S_CEV);
        o_cmd.wr     = (r_state == S_WRITE);
        o_cmd.out    = (r_state == S_OUT) && i_st.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

@@ rtl/core/pre_dp.sv @@
module pre_dp import pre_pkg::*; #(
    parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
    parameter int PAGE_SHIFT     = PAGE_SHIFT_DEF,
    parameter int REF_COUNT_BITS = REF_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [OP_W-1:0]       i_op,
    input  logic [VA_W-1:0]       i_va,
    input  logic [NFR_W-1:0]      i_num_frames,
    input  logic [POL_W-1:0]      i_policy,
    input  t_cmd                  i_cmd,
    output t_status               o_st,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUTC_W-1:0]     o_outcome,
    output logic [FIDX_W-1:0]     o_frame_index,
    output logic [PAGE_W-1:0]     o_evicted_page,
    output logic [ACC_W-1:0]      o_access_total,
    output logic [CNT_W-1:0]      o_fault_total,
    output logic [CNT_W-1:0]      o_disk_write_total
);
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int R   = REF_COUNT_BITS;
    localparam int EW  = PAGE_W + 1 + R + STAMP_W;
    localparam int REF_LO = STAMP_W;
    localparam int DRT_B  = STAMP_W + R;
    localparam int PG_LO  = STAMP_W + R + 1;
    localparam logic [CW-1:0] N_MAX = CW'(MAX_FRAMES);

    // item and bookkeeping registers
    logic              r_wr, r_hit, r_evict;
    logic [PAGE_W-1:0] r_page;
    logic [STAMP_W-1:0] r_stamp, r_use_ctr, r_best_key;
    logic [CW-1:0]     r_n, r_used, r_ptr, r_resident;
    logic              r_cmp_vld;
    logic [FW-1:0]     r_cmp_idx, r_frame, r_hand, r_h;
    logic [EW-1:0]     r_ent;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_flt, r_dwr;
    logic [OUTC_W-1:0] r_outcome;
    logic [PAGE_W-1:0] r_evicted;
    logic              r_out_vld;
    logic [OUTC_W-1:0] r_o_outcome;
    logic [FIDX_W-1:0] r_o_frame;
    logic [PAGE_W-1:0] r_o_evicted;
    logic [ACC_W-1:0]  r_o_acc;
    logic [CNT_W-1:0]  r_o_flt, r_o_dwr;

    logic [CW-1:0]     n_cfg;
    logic [EW-1:0]     rd_data, wr_data;
    logic              rd_en, we;
    logic [FW-1:0]     rd_addr, wr_addr;
    logic              match_now;
    logic [STAMP_W-1:0] key;
    logic [R-1:0]      rd_ref, ent_ref;
    logic [FW-1:0]     h_next;
    logic [ACC_W:0]    acc_sum;
    logic [CNT_W:0]    flt_sum, dwr_sum;
    logic              ent_dirty;

    // frames in use from the register
    always_comb begin
        if (i_num_frames == '0) n_cfg = CW'(1);
        else if (32'(i_num_frames) > MAX_FRAMES) n_cfg = N_MAX;
        else n_cfg = CW'(i_num_frames);
    end

    assign rd_ref    = rd_data[REF_LO +: R];
    assign ent_ref   = r_ent[REF_LO +: R];
    assign ent_dirty = r_ent[DRT_B];
    assign match_now = r_cmp_vld && (rd_data[PG_LO +: PAGE_W] == r_page);
    assign key       = (i_policy == POL_LRU) ? rd_data[STAMP_W-1:0] : STAMP_W'(rd_ref);
    assign h_next    = ((CW+1)'(r_h) + (CW+1)'(1) == (CW+1)'(r_n)) ? '0 : r_h + FW'(1);
    assign acc_sum   = {1'b0, r_acc} + ((i_op == OP_MODIFY) ? (ACC_W+1)'(2) : (ACC_W+1)'(1));
    assign flt_sum   = {1'b0, r_flt} + (CNT_W+1)'(1);
    assign dwr_sum   = {1'b0, r_dwr} + (CNT_W+1)'(1);

    // frame table read side
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr[FW-1:0];
        if (i_cmd.look) begin
            rd_en = (r_ptr < r_used) && !match_now && !r_hit;
        end else if (i_cmd.scan) begin
            rd_en = (r_ptr < r_n);
        end else if (i_cmd.crd) begin
            rd_en   = 1'b1;
            rd_addr = r_h;
        end
    end

    // frame table write side
    always_comb begin
        we      = 1'b0;
        wr_addr = r_frame;
        wr_data = r_ent;
        if (i_cmd.cev && rd_ref != '0) begin
            we      = 1'b1;
            wr_addr = r_h;
            wr_data = rd_data;
            wr_data[REF_LO +: R] = '0;
        end else if (i_cmd.wr) begin
            we = 1'b1;
            wr_data[STAMP_W-1:0]   = r_stamp;
            wr_data[PG_LO +: PAGE_W] = r_page;
            if (r_hit) begin
                wr_data[REF_LO +: R] = (ent_ref == '1) ? ent_ref : ent_ref + R'(1);
                wr_data[DRT_B]       = ent_dirty | r_wr;
            end else begin
                wr_data[REF_LO +: R] = R'(1);
                wr_data[DRT_B]       = r_wr;
            end
        end
    end

    pre_ram #(
        .WIDTH (EW),
        .DEPTH (1 << FW)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // control state: counters, hand, fill count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_ctr  <= '0;
            r_acc      <= '0;
            r_flt      <= '0;
            r_dwr      <= '0;
            r_resident <= '0;
            r_hand     <= '0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en && (i_cmd.look || i_cmd.scan);
            if (i_cmd.load) begin
                r_use_ctr <= r_use_ctr + STAMP_W'(1);
                r_acc     <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            end
            if (i_cmd.choose) begin
                r_flt <= flt_sum[CNT_W] ? '1 : flt_sum[CNT_W-1:0];
                if (r_resident < r_n) r_resident <= r_resident + CW'(1);
            end
            if (i_cmd.cev && rd_ref == '0) begin
                r_hand <= h_next;
            end
            if (i_cmd.wr && r_evict && ent_dirty) begin
                r_dwr <= dwr_sum[CNT_W] ? '1 : dwr_sum[CNT_W-1:0];
            end
            if (i_cmd.out) r_out_vld <= 1'b1;
            else if (i_out_ready) r_out_vld <= 1'b0;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wr      <= (i_op == OP_STORE) || (i_op == OP_MODIFY);
            r_page    <= PAGE_W'(i_va >> PAGE_SHIFT);
            r_stamp   <= r_use_ctr;
            r_n       <= n_cfg;
            r_used    <= (r_resident < n_cfg) ? r_resident : n_cfg;
            r_ptr     <= '0;
            r_hit     <= 1'b0;
            r_evict   <= 1'b0;
            r_outcome <= OUTC_HIT;
            r_evicted <= '0;
        end
        // associative lookup, one frame a cycle
        if (i_cmd.look) begin
            if (rd_en) r_ptr <= r_ptr + CW'(1);
            r_cmp_idx <= r_ptr[FW-1:0];
            if (match_now) begin
                r_hit   <= 1'b1;
                r_frame <= r_cmp_idx;
                r_ent   <= rd_data;
            end
        end
        if (i_cmd.choose) begin
            r_ptr <= '0;
            r_h   <= r_hand;
            if (r_resident < r_n) begin
                r_frame   <= r_resident[FW-1:0];
                r_outcome <= OUTC_FREE;
            end else begin
                r_evict <= 1'b1;
            end
        end
        // lowest key search
        if (i_cmd.scan) begin
            if (rd_en) r_ptr <= r_ptr + CW'(1);
            r_cmp_idx <= r_ptr[FW-1:0];
            if (r_cmp_vld && (r_cmp_idx == '0 || key < r_best_key)) begin
                r_best_key <= key;
                r_frame    <= r_cmp_idx;
                r_ent      <= rd_data;
            end
        end
        // bring the hand into range
        if (i_cmd.modr && (CW+1)'(r_h) >= (CW+1)'(r_n)) begin
            r_h <= r_h - FW'(r_n);
        end
        // second chance step
        if (i_cmd.cev) begin
            if (rd_ref != '0) begin
                r_h <= h_next;
            end else begin
                r_frame <= r_h;
                r_ent   <= rd_data;
            end
        end
        if (i_cmd.wr && r_evict) begin
            r_evicted <= r_ent[PG_LO +: PAGE_W];
            r_outcome <= ent_dirty ? OUTC_DIRTY : OUTC_CLEAN;
        end
        // output word
        if (i_cmd.out) begin
            r_o_outcome <= r_outcome;
            r_o_frame   <= FIDX_W'(r_frame);
            r_o_evicted <= r_evicted;
            r_o_acc     <= r_acc;
            r_o_flt     <= r_flt;
            r_o_dwr     <= r_dwr;
        end
    end

    // status to the controller
    always_comb begin
        o_st           = '0;
        o_st.hit_now   = match_now;
        o_st.look_miss = !r_cmp_vld && !r_hit && (r_ptr >= r_used);
        o_st.room      = (r_resident < r_n);
        o_st.scan_done = !r_cmp_vld && (r_ptr >= r_n);
        o_st.mod_done  = ((CW+1)'(r_h) < (CW+1)'(r_n));
        o_st.ref_nz    = (rd_ref != '0);
        o_st.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid        = r_out_vld;
    assign o_outcome          = r_o_outcome;
    assign o_frame_index      = r_o_frame;
    assign o_evicted_page     = r_o_evicted;
    assign o_access_total     = r_o_acc;
    assign o_fault_total      = r_o_flt;
    assign o_disk_write_total = r_o_dwr;
endmodule

@@ rtl/core/page_replacement_engine_top.sv @@
// Page replacement engine: takes one access word (op, 32-bit virtual address), looks the page
// up among the resident frames, fills free frames in order and otherwise evicts a victim by
// clock (second chance), LRU or NFU, and returns one result word with running totals. One item
// is worked at a time in a single frame table memory with a registered read port. The lookup
// compares one frame per cycle; an LRU or NFU eviction adds one pass over the frames in use;
// a clock eviction first subtracts n from the hand until it is in range, then visits frames
// from the hand, clearing each set reference count, until one is clear, at most n+1 frames.
// The result waits in an output register, so the next word is taken while it is still unread.
// The user must write registers only while no item is in work; the block does not enforce it.
module page_replacement_engine_top import pre_pkg::*; #(
    parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
    parameter int PAGE_SHIFT     = PAGE_SHIFT_DEF,
    parameter int REF_COUNT_BITS = REF_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // op [1:0], virtual_address [33:2], zero fill [39:34]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // outcome [1:0], frame_index [7:2], evicted_page [26:8], access_total [66:27],
    // fault_total [98:67], disk_write_total [130:99], zero fill [135:131]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata
);
    logic [NFR_W-1:0]  r_num_frames;
    logic [POL_W-1:0]  r_policy;
    t_cmd              cmd;
    t_status           st;
    logic [OUTC_W-1:0] outcome;
    logic [FIDX_W-1:0] frame_index;
    logic [PAGE_W-1:0] evicted_page;
    logic [ACC_W-1:0]  access_total;
    logic [CNT_W-1:0]  fault_total, disk_write_total;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_frames <= NFR_W'(64);
            r_policy     <= POL_CLOCK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_FRAMES: r_num_frames <= i_cfg_wdata[NFR_W-1:0];
                CFG_POLICY:     r_policy     <= i_cfg_wdata[POL_W-1:0];
                default:        r_policy     <= r_policy;
            endcase
        end
    end

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_policy   (r_policy),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    pre_dp #(
        .MAX_FRAMES     (MAX_FRAMES),
        .PAGE_SHIFT     (PAGE_SHIFT),
        .REF_COUNT_BITS (REF_COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (s_axis_tdata[1:0]),
        .i_va               (s_axis_tdata[33:2]),
        .i_num_frames       (r_num_frames),
        .i_policy           (r_policy),
        .i_cmd              (cmd),
        .o_st               (st),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_outcome          (outcome),
        .o_frame_index      (frame_index),
        .o_evicted_page     (evicted_page),
        .o_access_total     (access_total),
        .o_fault_total      (fault_total),
        .o_disk_write_total (disk_write_total)
    );

    // result word packing
    assign m_axis_tdata = {5'b0, disk_write_total, fault_total, access_total,
                           evicted_page, frame_index, outcome};

    logic [5:0] unused_pad;
    assign unused_pad = s_axis_tdata[39:34];
endmodule

@@ rtl/core/pre_checker.sv @@
module pre_checker import pre_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);
    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");

    // no eviction means no evicted page
    a_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == OUTC_HIT || m_axis_tdata[1:0] == OUTC_FREE)
        |-> m_axis_tdata[26:8] == '0)
        else $error("evicted page without eviction");

    // dirty eviction is counted
    a_dirty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == OUTC_DIRTY |-> m_axis_tdata[130:99] != '0)
        else $error("dirty eviction not counted");
endmodule

bind page_replacement_engine_top pre_checker u_pre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_page_replacement_engine_top.sv @@
module tb_page_replacement_engine_top;
    import pre_pkg::*;

    localparam int NFRAMES    = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;

    // one result word as it leaves the block
    typedef struct packed {
        logic [4:0]        fill;
        logic [CNT_W-1:0]  disk_writes;
        logic [CNT_W-1:0]  faults;
        logic [ACC_W-1:0]  accesses;
        logic [PAGE_W-1:0] evicted;
        logic [FIDX_W-1:0] frame;
        logic [OUTC_W-1:0] outcome;
    } t_result;

    // paging predictor with its queue of pending results
    class paging_scoreboard;
        logic [PAGE_W-1:0]  page_of [NFRAMES];
        bit                 dirty_of [NFRAMES];
        bit [15:0]          refs_of [NFRAMES];
        bit [STAMP_W-1:0]   stamp_of [NFRAMES];
        int unsigned        loaded;
        int unsigned        hand;
        bit [STAMP_W-1:0]   tick;
        bit [ACC_W-1:0]     accesses;
        bit [CNT_W-1:0]     faults;
        bit [CNT_W-1:0]     disk_writes;
        bit [NFR_W-1:0]     frames_cfg;
        bit [POL_W-1:0]     policy_cfg;
        t_result            pending[$];
        int                 errors;

        function void reset_state();
            for (int i = 0; i < NFRAMES; i++) begin
                page_of[i] = '0;
                dirty_of[i] = 0;
                refs_of[i] = 0;
                stamp_of[i] = 0;
            end
            loaded = 0;
            hand = 0;
            tick = 0;
            accesses = 0;
            faults = 0;
            disk_writes = 0;
            frames_cfg = 7'd64;
            policy_cfg = POL_CLOCK;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_NUM_FRAMES) frames_cfg = val;
            else policy_cfg = val[POL_W-1:0];
        endfunction

        // note one accepted access word and queue the result it should cause
        function void note_access(logic [IN_DATA_W-1:0] word);
            logic [OP_W-1:0]   op;
            logic [PAGE_W-1:0] page;
            bit                wr;
            int unsigned       n, used, fr, best;
            bit                hit;
            bit [STAMP_W-1:0]  st;
            t_result           r;
            op = word[OP_W-1:0];
            page = PAGE_W'(word[OP_W+VA_W-1:OP_W] >> PAGE_SHIFT_DEF);
            wr = (op == OP_STORE) || (op == OP_MODIFY);
            n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES ? NFRAMES : frames_cfg);
            used = (loaded < n) ? loaded : n;
            st = tick;
            tick = tick + 1;
            if (op == OP_MODIFY)
                accesses = (accesses >= 40'hFF_FFFF_FFFE) ? 40'hFF_FFFF_FFFF : accesses + 2;
            else if (accesses != 40'hFF_FFFF_FFFF)
                accesses = accesses + 1;
            r = '0;
            r.outcome = OUTC_HIT;
            hit = 0;
            fr = 0;
            for (int i = 0; i < used; i++) begin
                if (!hit && page_of[i] == page) begin
                    hit = 1;
                    fr = i;
                end
            end
            if (hit) begin
                if (refs_of[fr] != 16'hFFFF) refs_of[fr] = refs_of[fr] + 16'd1;
                stamp_of[fr] = st;
                if (wr) dirty_of[fr] = 1;
            end else begin
                if (faults != '1) faults = faults + 1;
                if (loaded < n) begin
                    fr = loaded;
                    loaded = loaded + 1;
                    r.outcome = OUTC_FREE;
                end else begin
                    if (policy_cfg == POL_LRU || policy_cfg == POL_NFU) begin
                        best = 0;
                        for (int i = 1; i < n; i++) begin
                            if (policy_cfg == POL_LRU ? (stamp_of[i] < stamp_of[best])
                                                      : (refs_of[i] < refs_of[best]))
                                best = i;
                        end
                        fr = best;
                    end else begin
                        // second chance: clear set flags until one is found clear
                        fr = hand % n;
                        while (refs_of[fr] != 0) begin
                            refs_of[fr] = 0;
                            fr = (fr + 1) % n;
                        end
                        hand = (fr + 1) % n;
                    end
                    r.evicted = page_of[fr];
                    if (dirty_of[fr]) begin
                        r.outcome = OUTC_DIRTY;
                        if (disk_writes != '1) disk_writes = disk_writes + 1;
                    end else begin
                        r.outcome = OUTC_CLEAN;
                    end
                end
                page_of[fr] = page;
                dirty_of[fr] = wr;
                refs_of[fr] = 1;
                stamp_of[fr] = st;
            end
            r.frame = FIDX_W'(fr);
            r.accesses = accesses;
            r.faults = faults;
            r.disk_writes = disk_writes;
            pending.push_back(r);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] word);
            t_result got, exp;
            bit bad;
            got = word;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", word);
                return;
            end
            exp = pending.pop_front();
            bad = (got.outcome !== exp.outcome) || (got.frame !== exp.frame)
                || (got.evicted !== exp.evicted) || (got.accesses !== exp.accesses)
                || (got.faults !== exp.faults) || (got.disk_writes !== exp.disk_writes)
                || (got.fill !== 5'd0);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: outcome %0d/%0d frame %0d/%0d evicted %h/%h ",
                              "acc %0d/%0d faults %0d/%0d writes %0d/%0d (exp/got)"},
                             exp.outcome, got.outcome, exp.frame, got.frame,
                             exp.evicted, got.evicted, exp.accesses, got.accesses,
                             exp.faults, got.faults, exp.disk_writes, got.disk_writes);
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_wdata = '0;

    paging_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_go = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  rx_period = 1;
    int  rx_duty = 1;
    int  rx_phase = 0;
    int  rx_epoch = 0;
    int  burst_left = 0;
    logic [PAGE_W-1:0] pool[$];

    page_replacement_engine_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // word monitors on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_access(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || sb.pending.size() == 0 && !s_axis_tvalid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: duty pattern re-chosen now and then, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 0;
        end else begin
            if (rx_epoch == 0) begin
                rx_period <= $urandom_range(1, 12);
                rx_duty <= $urandom_range(0, 12);
                rx_epoch <= $urandom_range(100, 600);
                rx_phase <= 0;
                m_axis_tready <= 1;
            end else begin
                rx_epoch <= rx_epoch - 1;
                rx_phase <= (rx_phase + 1 >= rx_period) ? 0 : rx_phase + 1;
                m_axis_tready <= (rx_phase < rx_duty) || (rx_duty == 0 && rx_phase == 0);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // offer one access word and hold it until taken, then maybe leave a gap
    task automatic send_access(logic [OP_W-1:0] op, logic [VA_W-1:0] va);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, va, op};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // let the block drain before touching registers
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic run_phase(int nfr, int pol, int count);
        int n;
        wait_drained();
        write_reg(CFG_NUM_FRAMES, CFG_DAT_W'(nfr));
        write_reg(CFG_POLICY, CFG_DAT_W'(pol));
        n = (nfr == 0) ? 1 : (nfr > NFRAMES ? NFRAMES : nfr);
        // working set a bit larger than the frames so hits and evictions mix
        pool.delete();
        repeat ($urandom_range(n, n + n / 2 + 2)) pool.push_back(PAGE_W'($urandom_range(0, 300)));
        pool.push_back(19'h7FFFF);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 8)
                send_access(OP_W'($urandom_range(0, 3)),
                            {pool[$urandom_range(0, pool.size() - 1)], 13'($urandom)});
            else
                send_access(OP_W'($urandom_range(0, 3)), $urandom);
        end
    endtask

    initial begin
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes and every access kind at reset settings
        send_access(OP_READ, 32'h0000_0000);
        send_access(OP_STORE, 32'hFFFF_FFFF);
        send_access(OP_MODIFY, 32'h0000_2000);
        send_access(2'd3, 32'h0000_4000);
        send_access(OP_STORE, 32'h0000_1FFF);
        send_access(OP_READ, 32'hFFFF_E000);
        send_access(OP_MODIFY, 32'h0000_4ABC);
        // directed: two frames, evict clean and dirty under each policy
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_reg(CFG_NUM_FRAMES, 7'd2);
            write_reg(CFG_POLICY, CFG_DAT_W'(p));
            send_access(OP_READ, 32'h0010_0000 + p * 32'h0010_0000);
            send_access(OP_STORE, 32'h0020_0000 + p * 32'h0010_0000);
            send_access(OP_READ, 32'h0030_0000);
            send_access(OP_MODIFY, 32'h0040_0000);
        end

        // random phases, extremes of frame count and policy among them
        run_phase(64, POL_CLOCK, 90);
        // long receiver hold-off while the next phase keeps offering words
        wait_drained();
        hold_go = 1;
        run_phase(64, POL_LRU, 90);
        run_phase(64, POL_NFU, 90);
        run_phase(1, POL_CLOCK, 90);
        run_phase(1, POL_LRU, 90);
        run_phase(1, POL_NFU, 90);
        run_phase(0, 3, 90);
        run_phase(127, POL_LRU, 90);
        run_phase(65, POL_NFU, 90);
        run_phase(5, POL_CLOCK, 90);
        run_phase(16, POL_LRU, 90);
        run_phase(3, POL_NFU, 90);
        run_phase(32, POL_CLOCK, 90);
        run_phase(2, 3, 90);
        run_phase(8, POL_NFU, 90);
        run_phase(48, POL_LRU, 90);

        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
